[rtl/tlik_pkg.sv]
// Shared constants, types and the arctangent table for the two-link planar
// inverse kinematics block. No dependencies.
`timescale 1ns / 1ps

package tlik_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 14;

  localparam int LEN_W  = 14;
  localparam int LSQ_W  = 2 * LEN_W;
  localparam int C_W    = 14;
  localparam int S_W    = 13;
  localparam int Q_W    = 13;
  localparam int NMAG_W = 30;
  localparam int DEN_W  = 29;
  localparam int LSUM_W = 29;
  localparam int DIST_W = 16;
  localparam int ANG_W  = 34;
  localparam int SH_W   = 16;
  localparam int EL_W   = 14;
  localparam int ONE_Q12 = 4096;

  localparam logic [LEN_W-1:0] UPPER_RST = 14'd8192;
  localparam logic [LEN_W-1:0] LOWER_RST = 14'd6144;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;

  localparam int SH_MIN = -25736;
  localparam int SH_MAX = 12868;
  localparam int EL_MAX = 12868;

  typedef enum logic [0:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic neg;
    logic dz;
  } div_tag_t;

  function automatic logic [ANG_W-1:0] atan_q30(input int i);
    logic [ANG_W-1:0] v;
    unique case (i)
      0:  v = 34'd843314857;
      1:  v = 34'd497837829;
      2:  v = 34'd263043837;
      3:  v = 34'd133525159;
      4:  v = 34'd67021687;
      5:  v = 34'd33543516;
      6:  v = 34'd16775851;
      7:  v = 34'd8388437;
      8:  v = 34'd4194283;
      9:  v = 34'd2097149;
      10: v = 34'd1048576;
      11: v = 34'd524288;
      12: v = 34'd262144;
      13: v = 34'd131072;
      14: v = 34'd65536;
      15: v = 34'd32768;
      16: v = 34'd16384;
      17: v = 34'd8192;
      18: v = 34'd4096;
      19: v = 34'd2048;
      20: v = 34'd1024;
      21: v = 34'd512;
      22: v = 34'd256;
      23: v = 34'd128;
      24: v = 34'd64;
      25: v = 34'd32;
      26: v = 34'd16;
      27: v = 34'd8;
      28: v = 34'd4;
      29: v = 34'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tlik_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module tlik_isqrt #(
  parameter int IN_W = 32
) (
  input  logic                    clk_i,
  input  logic [IN_W-1:0]         v_i,
  output logic [(IN_W+1)/2-1:0]   root_o
);
  localparam int RES_W = (IN_W + 1) / 2;
  localparam int TW    = 2 * RES_W + 1;

  logic [TW-1:0]    rem_q   [RES_W];
  logic [RES_W-1:0] root_q  [RES_W];
  logic [TW-1:0]    cur_rem [RES_W];
  logic [RES_W-1:0] cur_root[RES_W];
  logic [TW-1:0]    trial   [RES_W];

  always_comb begin
    for (int k = 0; k < RES_W; k++) begin
      if (k == 0) begin
        cur_rem[k]  = TW'(v_i);
        cur_root[k] = '0;
      end else begin
        cur_rem[k]  = rem_q[k-1];
        cur_root[k] = root_q[k-1];
      end
      trial[k] = (TW'(cur_root[k]) << (RES_W - k)) + (TW'(1) << (2 * (RES_W - 1 - k)));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_W; k++) begin
      if (cur_rem[k] >= trial[k]) begin
        rem_q[k]  <= cur_rem[k] - trial[k];
        root_q[k] <= cur_root[k] | (RES_W'(1) << (RES_W - 1 - k));
      end else begin
        rem_q[k]  <= cur_rem[k];
        root_q[k] <= cur_root[k];
      end
    end
  end

  assign root_o = root_q[RES_W-1];

endmodule

[rtl/tlik_div.sv]
// Pipelined restoring divider for the elbow cosine, one quotient bit per stage,
// with a saturation flag. Depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_div (
  input  logic                       clk_i,
  input  logic [tlik_pkg::NMAG_W-1:0] num_i,
  input  logic [tlik_pkg::DEN_W-1:0]  den_i,
  input  tlik_pkg::div_tag_t          tag_i,
  output logic [tlik_pkg::Q_W-1:0]    q_o,
  output logic                        sat_o,
  output tlik_pkg::div_tag_t          tag_o
);
  import tlik_pkg::*;

  localparam int RW = NMAG_W + Q_W - 1;

  logic [RW-1:0]    rem_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  logic             sat_q  [Q_W];
  div_tag_t         tag_q  [Q_W];
  logic [RW-1:0]    cur_rem[Q_W];
  logic [Q_W-1:0]   cur_quo[Q_W];
  logic [DEN_W-1:0] cur_den[Q_W];
  logic             cur_sat[Q_W];
  div_tag_t         cur_tag[Q_W];
  logic [RW-1:0]    trial  [Q_W];

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        cur_rem[k] = {num_i, {(Q_W-1){1'b0}}};
        cur_quo[k] = '0;
        cur_den[k] = den_i;
        cur_sat[k] = (NMAG_W+1)'(num_i) >= (NMAG_W+1)'({den_i, 1'b0});
        cur_tag[k] = tag_i;
      end else begin
        cur_rem[k] = rem_q[k-1];
        cur_quo[k] = quo_q[k-1];
        cur_den[k] = den_q[k-1];
        cur_sat[k] = sat_q[k-1];
        cur_tag[k] = tag_q[k-1];
      end
      trial[k] = RW'(cur_den[k]) << (Q_W - 1 - k);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Q_W; k++) begin
      if (cur_rem[k] >= trial[k]) begin
        rem_q[k] <= cur_rem[k] - trial[k];
        quo_q[k] <= cur_quo[k] | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_q[k] <= cur_rem[k];
        quo_q[k] <= cur_quo[k];
      end
      den_q[k] <= cur_den[k];
      sat_q[k] <= cur_sat[k];
      tag_q[k] <= cur_tag[k];
    end
  end

  assign q_o   = quo_q[Q_W-1];
  assign sat_o = sat_q[Q_W-1];
  assign tag_o = tag_q[Q_W-1];

endmodule

[rtl/tlik_front.sv]
// Front part: target distance, clamping, elbow cosine and sine, one target per
// cycle. Depends on tlik_pkg, tlik_isqrt and tlik_div.
`timescale 1ns / 1ps

module tlik_front #(
  parameter int DATA_WIDTH = tlik_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [DATA_WIDTH-1:0]      x_i,
  input  logic signed [DATA_WIDTH-1:0]      y_i,
  input  logic [tlik_pkg::LEN_W-1:0]        upper_i,
  input  logic [tlik_pkg::LEN_W-1:0]        lower_i,
  output logic                              valid_o,
  output logic signed [DATA_WIDTH-1:0]      x_o,
  output logic signed [DATA_WIDTH-1:0]      y_o,
  output logic signed [tlik_pkg::C_W-1:0]   c_o,
  output logic [tlik_pkg::S_W-1:0]          s_o
);
  import tlik_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int SQ_W   = 2 * DW;
  localparam int RT_W   = (SQ_W + 1) / 2;
  localparam int DCW    = ((RT_W > DIST_W) ? RT_W : DIST_W) + 2;
  localparam int DD_W   = 2 * DIST_W;
  localparam int CSQ_W  = 25;
  localparam int RAD_W  = 26;
  localparam int SR_W   = (RAD_W + 1) / 2;
  localparam int FL     = RT_W + Q_W + SR_W + 8;
  localparam int CL     = SR_W + 2;

  logic signed [SQ_W-1:0]   xx_q, yy_q;
  logic [SQ_W-1:0]          sum_q;
  logic [RT_W-1:0]          root;
  logic signed [DIST_W-1:0] lim_q;
  logic [LSQ_W-1:0]         l1sq_q, l2sq_q;
  logic [LSUM_W-1:0]        lsum_q;
  logic [DEN_W-1:0]         den_q;
  logic signed [DCW-1:0]    dr, dlim, dcl;
  logic signed [DIST_W-1:0] d_q;
  logic signed [DD_W-1:0]   dd_q, num;
  logic [NMAG_W-1:0]        nmag_q;
  div_tag_t                 tag_q, tag_div;
  logic [Q_W-1:0]           quo;
  logic                     sat;
  logic [Q_W-1:0]           cm;
  logic signed [C_W-1:0]    c_q;
  logic signed [2*C_W-1:0]  csq_full;
  logic [CSQ_W-1:0]         csq_q;
  logic [RAD_W-1:0]         rad_q;
  logic [SR_W-1:0]          s_root;
  logic                     vld_q [FL];
  logic signed [DW-1:0]     xs_q  [FL];
  logic signed [DW-1:0]     ys_q  [FL];
  logic signed [C_W-1:0]    cs_q  [CL];

  always_ff @(posedge clk_i) begin
    xx_q   <= SQ_W'(x_i) * SQ_W'(x_i);
    yy_q   <= SQ_W'(y_i) * SQ_W'(y_i);
    sum_q  <= unsigned'(xx_q) + unsigned'(yy_q);
    lim_q  <= $signed(DIST_W'(upper_i) + DIST_W'(lower_i) - DIST_W'(1));
    l1sq_q <= LSQ_W'(upper_i) * LSQ_W'(upper_i);
    l2sq_q <= LSQ_W'(lower_i) * LSQ_W'(lower_i);
    lsum_q <= LSUM_W'(l1sq_q) + LSUM_W'(l2sq_q);
    den_q  <= {LSQ_W'(upper_i) * LSQ_W'(lower_i), 1'b0};
  end

  tlik_isqrt #(.IN_W(SQ_W)) u_dist (
    .clk_i  (clk_i),
    .v_i    (sum_q),
    .root_o (root)
  );

  always_comb begin
    dr   = $signed(DCW'(root));
    dlim = DCW'(lim_q);
    dcl  = (dr < DCW'(1)) ? DCW'(1) : dr;
    if (dcl > dlim) begin
      dcl = dlim;
    end
    num = dd_q - $signed({{(DD_W-LSUM_W){1'b0}}, lsum_q});
  end

  always_ff @(posedge clk_i) begin
    d_q        <= dcl[DIST_W-1:0];
    dd_q       <= DD_W'(d_q) * DD_W'(d_q);
    nmag_q     <= (num < 0) ? NMAG_W'(-num) : NMAG_W'(num);
    tag_q.neg  <= num < 0;
    tag_q.dz   <= den_q == '0;
  end

  tlik_div u_div (
    .clk_i (clk_i),
    .num_i (nmag_q),
    .den_i (den_q),
    .tag_i (tag_q),
    .q_o   (quo),
    .sat_o (sat),
    .tag_o (tag_div)
  );

  always_comb begin
    if (tag_div.dz || sat || quo > Q_W'(ONE_Q12)) begin
      cm = Q_W'(ONE_Q12);
    end else begin
      cm = quo;
    end
    csq_full = c_q * c_q;
  end

  always_ff @(posedge clk_i) begin
    c_q   <= (tag_div.neg && !tag_div.dz) ? -$signed(C_W'(cm)) : $signed(C_W'(cm));
    csq_q <= csq_full[CSQ_W-1:0];
    rad_q <= RAD_W'(ONE_Q12 * ONE_Q12) - RAD_W'(csq_q);
  end

  tlik_isqrt #(.IN_W(RAD_W)) u_sine (
    .clk_i  (clk_i),
    .v_i    (rad_q),
    .root_o (s_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < FL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q[0] <= x_i;
    ys_q[0] <= y_i;
    for (int k = 1; k < FL; k++) begin
      xs_q[k] <= xs_q[k-1];
      ys_q[k] <= ys_q[k-1];
    end
    cs_q[0] <= c_q;
    for (int k = 1; k < CL; k++) begin
      cs_q[k] <= cs_q[k-1];
    end
  end

  assign valid_o = vld_q[FL-1];
  assign x_o     = xs_q[FL-1];
  assign y_o     = ys_q[FL-1];
  assign c_o     = cs_q[CL-1];
  assign s_o     = S_W'(s_root);

endmodule

[rtl/tlik_fifo.sv]
// Short queue between the front and back parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module tlik_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign empty_o = cnt_q == '0;
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH) || do_pop);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/tlik_cordic.sv]
// Pipelined vectoring CORDIC giving atan2 in Q4.30 radians.
// Depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_cordic #(
  parameter int CW           = 36,
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic signed [CW-1:0]               x_i,
  input  logic signed [CW-1:0]               y_i,
  output logic signed [tlik_pkg::ANG_W-1:0]  z_o
);
  import tlik_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0]    x_q [N+1];
  logic signed [CW-1:0]    y_q [N+1];
  logic signed [ANG_W-1:0] z_q [N+1];
  logic                    zf_q[N+1];

  always_ff @(posedge clk_i) begin
    zf_q[0] <= (x_i == '0 && y_i == '0) || (y_i == '0 && x_i > 0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        z_q[0] <= ANG_HALF_PI;
      end else begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        z_q[0] <= -ANG_HALF_PI;
      end
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
    for (int k = 0; k < N; k++) begin
      if (y_q[k] > 0) begin
        x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] + $signed(atan_q30(k));
      end else begin
        x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
        y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
        z_q[k+1] <= z_q[k] - $signed(atan_q30(k));
      end
      zf_q[k+1] <= zf_q[k];
    end
  end

  assign z_o = zf_q[N] ? '0 : z_q[N];

endmodule

[rtl/tlik_back.sv]
// Back part: forearm vector, three atan2 units and the final angle rounding.
// Depends on tlik_pkg and tlik_cordic.
`timescale 1ns / 1ps

module tlik_back #(
  parameter int DATA_WIDTH   = tlik_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [DATA_WIDTH-1:0]       x_i,
  input  logic signed [DATA_WIDTH-1:0]       y_i,
  input  logic signed [tlik_pkg::C_W-1:0]    c_i,
  input  logic [tlik_pkg::S_W-1:0]           s_i,
  input  logic [tlik_pkg::LEN_W-1:0]         upper_i,
  input  logic [tlik_pkg::LEN_W-1:0]         lower_i,
  output logic                               done_o,
  output logic signed [tlik_pkg::SH_W-1:0]   shoulder_o,
  output logic [tlik_pkg::EL_W-1:0]          elbow_o
);
  import tlik_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = ((DW + 14 > 30) ? DW + 14 : 30) + 3;
  localparam int BL   = CORDIC_STEPS + 3;
  localparam int ZD_W = ANG_W + 1;
  localparam int PR_W = LEN_W + C_W + 1;
  localparam int RND  = 1 << 17;

  logic signed [PR_W-1:0]  lc;
  logic signed [PR_W-1:0]  ls;
  logic signed [CW-1:0]    px_q, py_q, ex_q, ey_q, tx_q, ty_q;
  logic signed [ANG_W-1:0] zt, zp, ze;
  logic signed [ZD_W-1:0]  zd, zs, ze_r;
  logic signed [ZD_W-1:0]  sh_v, el_v;
  logic signed [SH_W-1:0]  sh_d;
  logic [EL_W-1:0]         el_d;
  logic                    vld_q [BL];

  assign lc = $signed({1'b0, lower_i}) * PR_W'(c_i);
  assign ls = $signed({1'b0, lower_i}) * $signed({1'b0, s_i});

  always_ff @(posedge clk_i) begin
    px_q <= (CW'($signed({1'b0, upper_i})) <<< 12) + CW'(lc);
    py_q <= CW'(ls);
    ex_q <= CW'(c_i) <<< 16;
    ey_q <= CW'($signed({1'b0, s_i})) <<< 16;
    tx_q <= CW'(x_i) <<< 14;
    ty_q <= CW'(y_i) <<< 14;
  end

  tlik_cordic #(.CW(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_tgt (
    .clk_i (clk_i), .x_i (tx_q), .y_i (ty_q), .z_o (zt)
  );

  tlik_cordic #(.CW(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_arm (
    .clk_i (clk_i), .x_i (px_q), .y_i (py_q), .z_o (zp)
  );

  tlik_cordic #(.CW(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_elb (
    .clk_i (clk_i), .x_i (ex_q), .y_i (ey_q), .z_o (ze)
  );

  always_comb begin
    zd   = ZD_W'(zt) - ZD_W'(zp);
    zs   = (zd + ZD_W'(RND)) >>> 18;
    ze_r = (ZD_W'(ze) + ZD_W'(RND)) >>> 18;
    sh_v = zs;
    el_v = ze_r;
    if (sh_v < ZD_W'(SH_MIN)) begin
      sh_v = ZD_W'(SH_MIN);
    end else if (sh_v > ZD_W'(SH_MAX)) begin
      sh_v = ZD_W'(SH_MAX);
    end
    if (el_v < 0) begin
      el_v = '0;
    end else if (el_v > ZD_W'(EL_MAX)) begin
      el_v = ZD_W'(EL_MAX);
    end
    sh_d = sh_v[SH_W-1:0];
    el_d = el_v[EL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    shoulder_o <= sh_d;
    elbow_o    <= el_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BL; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < BL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign done_o = vld_q[BL-1];

endmodule

[rtl/two_link_planar_inverse_kinematics.sv]
// Top level of the two-link planar arm inverse kinematics block: link length
// registers, front part, queue and back part. Depends on tlik_pkg and all rtl modules.
//
//   Channel   Handshake          Payload
//   target    start, busy        target_x_i, target_y_i
//   angles    done_o             shoulder_angle_o, elbow_angle_o
//   config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// A target may be given in every cycle; busy is never raised.
// Each result follows its target through the two square root pipelines,
// the cosine divider and the CORDIC pipelines.
// Reset clears the pipeline valid flags and loads the link lengths 2.0 and 1.5.
// The receiver cannot stall; a result is shown for exactly one cycle.
`timescale 1ns / 1ps

module two_link_planar_inverse_kinematics #(
  parameter int DATA_WIDTH   = tlik_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [DATA_WIDTH-1:0]      target_x_i,
  input  logic signed [DATA_WIDTH-1:0]      target_y_i,
  output logic                              done_o,
  output logic signed [tlik_pkg::SH_W-1:0]  shoulder_angle_o,
  output logic [tlik_pkg::EL_W-1:0]         elbow_angle_o,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [tlik_pkg::LEN_W-1:0]        cfg_data_i
);
  import tlik_pkg::*;

  localparam int QW = 2 * DATA_WIDTH + C_W + S_W;

  logic [LEN_W-1:0]            upper_q, lower_q;
  logic                        accept;
  logic                        f_valid;
  logic signed [DATA_WIDTH-1:0] f_x, f_y, b_x, b_y;
  logic signed [C_W-1:0]       f_c, b_c;
  logic [S_W-1:0]              f_s, b_s;
  logic [QW-1:0]               q_head;
  logic                        q_empty;
  logic                        b_valid;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RST;
      lower_q <= LOWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_UPPER: upper_q <= cfg_data_i;
        REG_LOWER: lower_q <= cfg_data_i;
      endcase
    end
  end

  tlik_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (target_x_i),
    .y_i     (target_y_i),
    .upper_i (upper_q),
    .lower_i (lower_q),
    .valid_o (f_valid),
    .x_o     (f_x),
    .y_o     (f_y),
    .c_o     (f_c),
    .s_o     (f_s)
  );

  tlik_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  ({f_x, f_y, f_c, f_s}),
    .pop_i   (!q_empty),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  assign b_valid = !q_empty;
  assign {b_x, b_y, b_c, b_s} = q_head;

  tlik_back #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_valid),
    .x_i        (b_x),
    .y_i        (b_y),
    .c_i        (b_c),
    .s_i        (b_s),
    .upper_i    (upper_q),
    .lower_i    (lower_q),
    .done_o     (done_o),
    .shoulder_o (shoulder_angle_o),
    .elbow_o    (elbow_angle_o)
  );

endmodule
